[rtl/signed_leb128_block_decoder_unit_defines.svh]
// Assertion macros for the signed LEB128 block decoder.
// Used by the top level only; the macros expect clk and rst_n in scope.
`ifndef SIGNED_LEB128_BLOCK_DECODER_UNIT_DEFINES_SVH
`define SIGNED_LEB128_BLOCK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/slb_pkg.sv]
// Shared types and codes of the signed LEB128 block decoder.
// No dependencies; the channel, configuration, core and top-level files take names from here by scope.
`default_nettype none

package slb_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LONG  = 3'd1;
  localparam logic [2:0] ST_PAST_SIZE = 3'd2;
  localparam logic [2:0] ST_TRAILING  = 3'd3;
  localparam logic [2:0] ST_ENDED     = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_WIDTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT      = 2'd2;

  typedef struct packed {
    logic        value_width_mode;
    logic [31:0] byte_budget;
    logic [31:0] value_count;
  } cfg_t;

  typedef struct packed {
    logic       first_of_block;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               value_valid;
    logic               last_value;
    logic [2:0]         status;
  } result_t;

endpackage

`default_nettype wire

[rtl/slb_channels.sv]
// Handshake channel interfaces of the signed LEB128 block decoder.
// Depends on slb_pkg for the configuration index width.
`default_nettype none

interface slb_in_if;
  logic       valid;
  logic       ready;
  logic       first_of_block;
  logic [7:0] data_byte;
  modport source (output valid, output first_of_block, output data_byte, input ready);
  modport sink (input valid, input first_of_block, input data_byte, output ready);
endinterface

interface slb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               value_valid;
  logic               last_value;
  logic [2:0]         status;
  modport source (output valid, output value, output value_valid, output last_value,
                  output status, input ready);
  modport sink (input valid, input value, input value_valid, input last_value,
                input status, output ready);
endinterface

interface slb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [slb_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/slb_cfg.sv]
// Configuration registers: width mode, byte budget and value count.
// Depends on slb_pkg for cfg_t and the register indexes.
`default_nettype none

module slb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [slb_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]                   wr_data,
  output slb_pkg::cfg_t                 cfg
);

  slb_pkg::cfg_t cfg_r;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.value_width_mode <= 1'b0;
      cfg_r.byte_budget      <= 32'd0;
      cfg_r.value_count      <= 32'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        slb_pkg::CFG_VALUE_WIDTH_MODE: cfg_r.value_width_mode <= wr_data[0];
        slb_pkg::CFG_BYTE_BUDGET:      cfg_r.byte_budget      <= wr_data;
        slb_pkg::CFG_VALUE_COUNT:      cfg_r.value_count      <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/slb_core.sv]
// Decode step: block state registers and the per-byte LEB128 logic.
// Depends on slb_pkg for cfg_t, in_item_t, result_t and status codes.
`default_nettype none

module slb_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  slb_pkg::in_item_t item,
  input  slb_pkg::cfg_t     cfg,
  output slb_pkg::result_t  res
);

  logic [31:0] partial_r, partial_nxt;
  logic [2:0]  grp_r, grp_nxt;
  logic [31:0] bytes_rem_r, bytes_rem_nxt;
  logic [31:0] vals_rem_r, vals_rem_nxt;
  logic        ended_r, ended_nxt;
  logic [2:0]  sticky_r, sticky_nxt;

  logic [31:0] partial_e, bytes_rem_e, vals_rem_e;
  logic [2:0]  grp_e, sticky_e, grp_inc;
  logic        ended_e, mode32;
  logic [5:0]  shift, shift_top;
  logic        too_long_at, too_long_inc, ext_ok;
  logic [31:0] width_mask, merged, ext_bits, sext, final_val;
  logic [31:0] bytes_dec, vals_dec;

  always_comb begin
    // Reload block state ahead of a first-of-block byte
    if (item.first_of_block) begin
      partial_e   = 32'd0;
      grp_e       = 3'd0;
      bytes_rem_e = cfg.byte_budget;
      vals_rem_e  = cfg.value_count;
      ended_e     = (cfg.value_count == 32'd0);
      sticky_e    = slb_pkg::ST_OK;
    end else begin
      partial_e   = partial_r;
      grp_e       = grp_r;
      bytes_rem_e = bytes_rem_r;
      vals_rem_e  = vals_rem_r;
      ended_e     = ended_r;
      sticky_e    = sticky_r;
    end

    mode32    = cfg.value_width_mode;
    shift     = ({3'b000, grp_e} << 3) - {3'b000, grp_e};
    shift_top = shift + 6'd7;
    grp_inc   = grp_e + 3'd1;

    // Group limits: three groups cover 16 bits, five cover 32 bits
    too_long_at  = mode32 ? (grp_e >= 3'd5) : (grp_e >= 3'd3);
    too_long_inc = mode32 ? (grp_inc >= 3'd5) : (grp_inc >= 3'd3);
    ext_ok       = mode32 ? (grp_e <= 3'd3) : (grp_e <= 3'd1);
    width_mask   = mode32 ? 32'hffff_ffff : 32'h0000_ffff;

    // Merge this group, then sign-extend from bit 6 when the top group is not full
    merged    = (partial_e | ({25'd0, item.data_byte[6:0]} << shift)) & width_mask;
    ext_bits  = (ext_ok && item.data_byte[6]) ? (32'hffff_ffff << shift_top) : 32'd0;
    sext      = (merged | ext_bits) & width_mask;
    final_val = mode32 ? sext : {{16{sext[15]}}, sext[15:0]};

    bytes_dec = bytes_rem_e - 32'd1;
    vals_dec  = vals_rem_e - 32'd1;

    partial_nxt   = partial_e;
    grp_nxt       = grp_e;
    bytes_rem_nxt = bytes_rem_e;
    vals_rem_nxt  = vals_rem_e;
    ended_nxt     = ended_e;
    res.value       = 32'sd0;
    res.value_valid = 1'b0;
    res.last_value  = 1'b0;
    res.status      = slb_pkg::ST_OK;

    if (sticky_e != slb_pkg::ST_OK) begin
      res.status = sticky_e;
    end else if (ended_e) begin
      res.status = slb_pkg::ST_ENDED;
    end else if (bytes_rem_e == 32'd0) begin
      res.status = slb_pkg::ST_PAST_SIZE;
    end else if (too_long_at) begin
      res.status = slb_pkg::ST_TOO_LONG;
    end else begin
      bytes_rem_nxt = bytes_dec;
      if (item.data_byte[7]) begin
        // Continuation: keep the partial value and advance the group
        partial_nxt = merged;
        grp_nxt     = grp_inc;
        if (too_long_inc) begin
          res.status = slb_pkg::ST_TOO_LONG;
        end
      end else begin
        // Final byte: emit the value and count it
        res.value       = final_val;
        res.value_valid = 1'b1;
        partial_nxt     = 32'd0;
        grp_nxt         = 3'd0;
        vals_rem_nxt    = vals_dec;
        if (vals_dec == 32'd0) begin
          res.last_value = 1'b1;
          ended_nxt      = 1'b1;
          if (bytes_dec != 32'd0) begin
            res.status = slb_pkg::ST_TRAILING;
          end
        end
      end
    end

    sticky_nxt = (res.status != slb_pkg::ST_OK) ? res.status : sticky_e;
  end

  // Hold block state between bytes; advance on each decoded item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= 32'd0;
      grp_r       <= 3'd0;
      bytes_rem_r <= 32'd0;
      vals_rem_r  <= 32'd0;
      ended_r     <= 1'b1;
      sticky_r    <= slb_pkg::ST_OK;
    end else if (step) begin
      partial_r   <= partial_nxt;
      grp_r       <= grp_nxt;
      bytes_rem_r <= bytes_rem_nxt;
      vals_rem_r  <= vals_rem_nxt;
      ended_r     <= ended_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/signed_leb128_block_decoder_unit.sv]
// Signed LEB128 block decoder. Takes one body byte per item and returns one result
// item per byte, at a sustained rate of one item per cycle unless the output stalls;
// an accepted byte passes the input register and then the result register. The rate
// is set by the single decode stage between the two, which reads the block state that
// the previous byte wrote at the same edge it moved on. Results carry the value
// (sign-extended from 16 or 32 bits), a completion flag, a last value flag and a
// status that stays sticky until the next first-of-block byte. The user must write
// configuration through the cfg channel only while the block is idle; no check enforces it.
`default_nettype none
`include "signed_leb128_block_decoder_unit_defines.svh"

module signed_leb128_block_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  slb_in_if.sink      in_ch,
  slb_out_if.source   out_ch,
  slb_cfg_if.sink     cfg_ch
);

  logic              in_vld_r;
  slb_pkg::in_item_t in_item_r;
  logic              out_vld_r;
  slb_pkg::result_t  out_res_r;
  slb_pkg::result_t  step_res;
  slb_pkg::cfg_t     cfg;
  logic              move;

  assign cfg_ch.ready = 1'b1;

  slb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // Advance the held byte whenever the result register is free or being taken
  assign move        = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || move;

  slb_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (move),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.first_of_block <= in_ch.first_of_block;
      in_item_r.data_byte      <= in_ch.data_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.value       = out_res_r.value;
  assign out_ch.value_valid = out_res_r.value_valid;
  assign out_ch.last_value  = out_res_r.last_value;
  assign out_ch.status      = out_res_r.status;

  // A final value is always a completed value
  `SLB_ASSERT_IMP(a_last_is_valid, out_vld_r && out_res_r.last_value, out_res_r.value_valid, "last value without completed value")
  // A completed value that reports trailing bytes is the final one
  `SLB_ASSERT_IMP(a_trailing_on_last, out_vld_r && out_res_r.value_valid && (out_res_r.status == slb_pkg::ST_TRAILING), out_res_r.last_value, "trailing status off the final value")
  // A held byte with a free result register moves on at the next edge
  `SLB_ASSERT_NXT(a_held_byte_moves, in_vld_r && !out_vld_r, out_vld_r, "held byte did not reach the result register")

endmodule

`default_nettype wire
